// ===== hw/rtl/nma_pkg.sv =====
package nma_pkg;

    // accumulator default and field widths
    localparam int ACC_WIDTH_DEF = 48;
    localparam int W_IN          = 16;
    localparam int W_OUT         = 32;
    localparam int W_ALPHA       = 16;
    localparam int W_MODE        = 2;
    localparam int CFG_IDX_W     = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd1;

    // activation codes, anything else is linear
    localparam logic [W_MODE-1:0] MODE_ELU = 2'd0;
    localparam logic [W_MODE-1:0] MODE_SIG = 2'd1;

    localparam logic [W_ALPHA-1:0] ALPHA_RST = 16'd4096;

    // shared multiplier and divider widths
    localparam int MUL_W     = 33;
    localparam int DIV_NUM_W = 61;
    localparam int DIV_DEN_W = 32;

    // exp range reduction
    localparam int REM_W = 21;
    localparam int K_W   = 6;
    localparam logic [REM_W-1:0]        LN2_Q16       = 21'd45426;
    localparam logic signed [MUL_W-1:0] EXP_FLOOR_Q16 = -33'sd1572864;
    localparam logic [3:0]              TAYLOR_TERMS  = 4'd10;

    localparam logic [30:0]       ONE_Q30 = 31'h4000_0000;
    localparam logic [W_OUT-1:0]  ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hw/rtl/nma_in_if.sv =====
interface nma_in_if
    import nma_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [W_IN-1:0]  weight;
    logic signed [W_IN-1:0]  sample;
    logic                    last_term;

    modport source (output valid, weight, sample, last_term, input ready);
    modport sink   (input valid, weight, sample, last_term, output ready);
endinterface

// ===== hw/rtl/nma_out_if.sv =====
interface nma_out_if
    import nma_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [W_OUT-1:0] act_value;
    logic signed [W_OUT-1:0] act_slope;

    modport source (output valid, act_value, act_slope, input ready);
    modport sink   (input valid, act_value, act_slope, output ready);
endinterface

// ===== hw/rtl/nma_div.sv =====
module nma_div
    import nma_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output t_div_stat        o_stat
);
    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           ge;

    // restoring step, one quotient bit a cycle
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], ge};
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== hw/rtl/neuron_mac_activation.sv =====
// neuron_mac_activation: multiply-accumulate neuron with elu / scaled sigmoid / linear output
// a term not marked last passes through the accept, multiply and accumulate states
// a last term in linear mode, or elu with a non-negative sum, then passes pre, select and done
// elu with a negative sum adds range reduction plus ten taylor terms (skipped below the floor),
// each term one pass of the 61-step shared divider; scaled sigmoid adds exp, a divide, two multiplies
// reset: synchronous, active low; clears accumulator, sequencer, output beat, act_mode=0, alpha=1.0
module neuron_mac_activation
    import nma_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    nma_in_if.sink               i_in,
    nma_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [W_ALPHA-1:0]   i_cfg_data
);

    // one-hot sequencer
    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_MAC   = 20'h00002,
        S_ACC   = 20'h00004,
        S_PRE   = 20'h00008,
        S_SEL   = 20'h00010,
        S_USAT  = 20'h00020,
        S_EXP0  = 20'h00040,
        S_EXPK  = 20'h00080,
        S_TMUL  = 20'h00100,
        S_TDIV  = 20'h00200,
        S_TWAIT = 20'h00400,
        S_EXPF  = 20'h00800,
        S_POST  = 20'h01000,
        S_ELU   = 20'h02000,
        S_QWAIT = 20'h04000,
        S_QMUL  = 20'h08000,
        S_QSQ   = 20'h10000,
        S_DMUL  = 20'h20000,
        S_SIG   = 20'h40000,
        S_DONE  = 20'h80000
    } t_state;

    t_state r_state;

    // configuration
    logic [W_MODE-1:0]  r_mode;
    logic [W_ALPHA-1:0] r_alpha;

    // accepted beat
    logic signed [W_IN-1:0] r_w;
    logic signed [W_IN-1:0] r_s;
    logic                   r_last;

    // datapath
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [W_OUT-1:0]     r_v;
    logic signed [W_OUT-1:0]     r_u;
    logic signed [MUL_W-1:0]     r_x;
    logic [REM_W-1:0]            r_rem;
    logic [K_W-1:0]              r_k;
    logic signed [MUL_W-1:0]     r_r30;
    logic signed [MUL_W-1:0]     r_term;
    logic signed [MUL_W:0]       r_sum;
    logic [3:0]                  r_i;
    logic                        r_tneg;
    logic [30:0]                 r_e;
    logic [30:0]                 r_q;
    logic [30:0]                 r_q2c;
    logic signed [W_OUT-1:0]     r_y;
    logic signed [W_OUT-1:0]     r_d;

    // output beat register
    logic                    r_ov;
    logic signed [W_OUT-1:0] r_val;
    logic signed [W_OUT-1:0] r_slope;

    // shared multiplier, registered
    logic signed [MUL_W-1:0]   m_a;
    logic signed [MUL_W-1:0]   m_b;
    logic signed [2*MUL_W-1:0] m_prod;
    logic signed [2*MUL_W-1:0] r_mp;

    logic signed [MUL_W-1:0] alpha_ext;
    assign alpha_ext = $signed({{(MUL_W-W_ALPHA){1'b0}}, r_alpha});

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_MAC: begin
                m_a = MUL_W'(r_w);
                m_b = MUL_W'(r_s);
            end
            S_SEL: begin
                m_a = alpha_ext;
                m_b = MUL_W'(r_v);
            end
            S_TMUL: begin
                m_a = r_term;
                m_b = r_r30;
            end
            S_POST: begin
                m_a = alpha_ext;
                m_b = $signed({2'b00, r_e}) - $signed({2'b00, ONE_Q30});
            end
            S_QMUL: begin
                m_a = $signed({2'b00, r_q});
                m_b = $signed({2'b00, r_q});
            end
            S_DMUL: begin
                m_a = alpha_ext;
                m_b = $signed({2'b00, r_q2c});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_prod = m_a * m_b;

    always_ff @(posedge i_clk) begin
        r_mp <= m_prod;
    end

    // saturating accumulate of the registered product
    logic signed [ACC_WIDTH:0]   acc_sum;
    logic signed [ACC_WIDTH-1:0] acc_next;
    assign acc_sum = $signed({r_acc[ACC_WIDTH-1], r_acc})
                   + $signed({{(ACC_WIDTH+1-2*W_IN){r_mp[2*W_IN-1]}}, r_mp[2*W_IN-1:0]});
    always_comb begin
        if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
            acc_next = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            acc_next = acc_sum[ACC_WIDTH-1:0];
        end
    end

    // sum to q16.16 with floor and saturation
    logic signed [ACC_WIDTH-1:0] acc_shr;
    logic                        acc_fits;
    logic signed [W_OUT-1:0]     v_sat;
    assign acc_shr  = r_acc >>> 8;
    assign acc_fits = (&acc_shr[ACC_WIDTH-1:W_OUT-1]) | ~(|acc_shr[ACC_WIDTH-1:W_OUT-1]);
    assign v_sat    = acc_fits ? acc_shr[W_OUT-1:0]
                    : (acc_shr[ACC_WIDTH-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // sigmoid argument alpha*v in q16.16, saturated
    logic signed [2*MUL_W-1:0] u_shr;
    logic                      u_fits;
    logic signed [W_OUT-1:0]   u_sat;
    logic signed [MUL_W-1:0]   u_abs;
    assign u_shr  = r_mp >>> 12;
    assign u_fits = (&u_shr[2*MUL_W-1:W_OUT-1]) | ~(|u_shr[2*MUL_W-1:W_OUT-1]);
    assign u_sat  = u_fits ? u_shr[W_OUT-1:0]
                  : (u_shr[2*MUL_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    assign u_abs  = u_sat[W_OUT-1] ? -MUL_W'(u_sat) : MUL_W'(u_sat);

    // exp helpers
    logic signed [MUL_W-1:0]   x_neg;
    logic signed [2*MUL_W-1:0] p_abs;
    logic signed [MUL_W:0]     sum_shr;
    assign x_neg   = -r_x;
    assign p_abs   = r_mp[2*MUL_W-1] ? -r_mp : r_mp;
    assign sum_shr = r_sum >>> r_k;

    // shared divider: taylor terms and the sigmoid ratio
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    t_div_stat            div_st;
    logic [30:0]          one_minus_e;
    logic signed [MUL_W-1:0] quo_s;
    logic signed [MUL_W-1:0] term_next;

    assign one_minus_e = ONE_Q30 - r_e;
    assign div_start   = (r_state == S_TDIV) || ((r_state == S_POST) && (r_mode == MODE_SIG));
    assign div_num     = (r_state == S_TDIV) ? DIV_NUM_W'(p_abs[2*MUL_W-1:30])
                                             : {one_minus_e, 30'd0};
    assign div_den     = (r_state == S_TDIV) ? DIV_DEN_W'(r_i)
                                             : DIV_DEN_W'(r_e) + DIV_DEN_W'(ONE_Q30);
    assign quo_s       = $signed(div_quo[MUL_W-1:0]);
    assign term_next   = r_tneg ? -quo_s : quo_s;

    nma_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_stat  (div_st)
    );

    // result shaping
    logic signed [W_OUT-1:0] sig_mag;
    assign sig_mag = $signed({15'd0, r_q[30:14]});

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_ov    <= 1'b0;
            r_mode  <= MODE_ELU;
            r_alpha <= ALPHA_RST;
        end else begin
            // config writes must arrive only while idle; the block itself does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:  r_mode  <= i_cfg_data[W_MODE-1:0];
                    CFG_ALPHA: r_alpha <= i_cfg_data;
                    default: ;
                endcase
            end

            // the done state reloads the beat itself
            if (o_out.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_w     <= i_in.weight;
                        r_s     <= i_in.sample;
                        r_last  <= i_in.last_term;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= acc_next;
                    r_state <= r_last ? S_PRE : S_IDLE;
                end
                S_PRE: begin
                    r_v     <= v_sat;
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    // sigmoid product alpha*v is formed this cycle
                    if (r_mode == MODE_SIG) begin
                        r_state <= S_USAT;
                    end else if ((r_mode == MODE_ELU) && r_acc[ACC_WIDTH-1]) begin
                        r_x     <= MUL_W'(r_v);
                        r_state <= S_EXP0;
                    end else begin
                        r_y     <= r_v;
                        r_d     <= ONE_Q16;
                        r_state <= S_DONE;
                    end
                end
                S_USAT: begin
                    r_u     <= u_sat;
                    r_x     <= -u_abs;
                    r_state <= S_EXP0;
                end
                S_EXP0: begin
                    // far negative argument gives exactly zero
                    if (r_x < EXP_FLOOR_Q16) begin
                        r_e     <= '0;
                        r_state <= S_POST;
                    end else begin
                        r_rem   <= x_neg[REM_W-1:0];
                        r_k     <= '0;
                        r_state <= S_EXPK;
                    end
                end
                S_EXPK: begin
                    // k = -x div ln2 by repeated subtraction
                    if (r_rem >= LN2_Q16) begin
                        r_rem <= r_rem - LN2_Q16;
                        r_k   <= r_k + 1'b1;
                    end else begin
                        r_r30   <= -($signed(MUL_W'(r_rem)) <<< 14);
                        r_term  <= $signed({2'b00, ONE_Q30});
                        r_sum   <= $signed({3'b000, ONE_Q30});
                        r_i     <= 4'd1;
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    r_tneg  <= r_mp[2*MUL_W-1];
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (div_st.done) begin
                        r_term <= term_next;
                        r_sum  <= r_sum + $signed({term_next[MUL_W-1], term_next});
                        if (r_i == TAYLOR_TERMS) begin
                            r_state <= S_EXPF;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_EXPF: begin
                    r_e     <= r_sum[MUL_W] ? 31'd0 : sum_shr[30:0];
                    r_state <= S_POST;
                end
                S_POST: begin
                    // elu multiplies here, sigmoid starts the ratio divide
                    r_state <= (r_mode == MODE_SIG) ? S_QWAIT : S_ELU;
                end
                S_ELU: begin
                    r_y     <= r_mp[57:26];
                    r_d     <= r_mp[57:26] + $signed({12'd0, r_alpha, 4'd0});
                    r_state <= S_DONE;
                end
                S_QWAIT: begin
                    if (div_st.done) begin
                        r_q     <= div_quo[30:0];
                        r_state <= S_QMUL;
                    end
                end
                S_QMUL: begin
                    r_state <= S_QSQ;
                end
                S_QSQ: begin
                    r_q2c   <= ONE_Q30 - r_mp[60:30];
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    r_state <= S_SIG;
                end
                S_SIG: begin
                    r_y     <= r_u[W_OUT-1] ? -sig_mag : sig_mag;
                    r_d     <= r_mp[58:27];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // wait for the output register to free up
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_val   <= r_y;
                        r_slope <= r_d;
                        r_acc   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.act_value = r_val;
    assign o_out.act_slope = r_slope;

    // checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_DONE) && (r_state == S_IDLE)) |-> (r_acc == '0))
        else $error("accumulator not cleared after result");

endmodule

// ===== dv/tb_neuron_mac_activation.sv =====
module tb_neuron_mac_activation;
    import nma_pkg::*;

    // codes with no name in the package: linear and the spare code (acts as linear)
    localparam logic [W_MODE-1:0] MODE_LIN   = 2'd2;
    localparam logic [W_MODE-1:0] MODE_SPARE = 2'd3;

    localparam int      CYCLE_LIMIT = 5_000_000;
    localparam int      RAND_ITEMS  = 1230;
    // enough max-product terms to push the q16.16 sum past its top
    localparam int      SAT_TERMS   = 520;
    localparam longint  Q30         = 64'sd1 << 30;
    localparam longint  Q16         = 64'sd65536;
    localparam longint  LN2         = 64'sd45426;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [W_ALPHA-1:0]   i_cfg_data;

    nma_in_if  in_if ();
    nma_out_if out_if ();

    neuron_mac_activation uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock, period 4
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    typedef struct {
        logic signed [W_OUT-1:0] value;
        logic signed [W_OUT-1:0] slope;
    } t_act;

    typedef struct {
        logic [W_MODE-1:0]      mode;
        logic [W_ALPHA-1:0]     gain;
        logic signed [W_IN-1:0] w;
        logic signed [W_IN-1:0] x;
        logic                   last;
        logic                   fixed;   // expected result typed in below
        logic signed [W_OUT-1:0] value;
        logic signed [W_OUT-1:0] slope;
    } t_row;

    // predictor state: own copy of the registers and the running sum
    logic [W_MODE-1:0]  mode_q;
    logic [W_ALPHA-1:0] gain_q;
    longint             dot_acc;

    t_act   act_q[$];
    int     fails;
    int     cycles;
    bit     sender_idle_on;
    bit     sink_idle_on;
    int     sink_hold;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // e^x for x <= 0 in q16.16, result q2.30: range reduction by ln2 then taylor series
    function automatic longint exp_q30(longint x);
        longint k, r, term, acc;
        if (x > 0) x = 0;
        if (x < -64'sd24 * Q16) return 0;
        k    = (-x) / LN2;
        r    = (x + k * LN2) * 64'sd16384;
        term = Q30;
        acc  = term;
        for (int i = 1; i <= 10; i++) begin
            term = (term * r) / (Q30 * i);
            acc += term;
        end
        if (acc < 0) acc = 0;
        return acc >>> k;
    endfunction

    // one accepted beat: accumulate, and on the last term work out the activation
    function automatic bit neuron_step(input logic signed [W_IN-1:0] w,
                                       input logic signed [W_IN-1:0] x,
                                       input logic last, output t_act res);
        longint accmax, accmin, p, a, v, y, d, u, s, e, q, q2, mag;
        accmax = (64'sd1 <<< 47) - 1;
        accmin = -accmax - 1;
        p = longint'(w) * longint'(x);
        a = longint'(gain_q);
        // saturating accumulate
        if (p > 0 && dot_acc > accmax - p) dot_acc = accmax;
        else if (p < 0 && dot_acc < accmin - p) dot_acc = accmin;
        else dot_acc += p;
        if (!last) return 1'b0;
        v = clip32(dot_acc >>> 8);
        if (mode_q == MODE_ELU) begin
            if (dot_acc >= 0) begin
                y = v;
                d = Q16;
            end else begin
                e = exp_q30(v);
                y = (a * (e - Q30)) >>> 26;
                d = y + a * 16;
            end
        end else if (mode_q == MODE_SIG) begin
            u   = clip32((a * v) >>> 12);
            s   = (u < 0) ? -u : u;
            e   = exp_q30(-s);
            q   = ((Q30 - e) << 30) / (Q30 + e);
            q2  = (q * q) >> 30;
            mag = q >> 14;
            y   = (u < 0) ? -mag : mag;
            d   = (a * (Q30 - q2)) >> 27;
        end else begin
            y = v;
            d = Q16;
        end
        dot_acc   = 0;
        res.value = clip32(y);
        res.slope = clip32(d);
        return 1'b1;
    endfunction

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_neuron_mac_activation: FAIL");
            $finish;
        end
    end

    // result side: ready with random stalls, mostly short and now and then long
    always @(negedge i_clk) begin
        if (!i_rst_n || !sink_idle_on) begin
            out_if.ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold    <= sink_hold - 1;
            out_if.ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            out_if.ready <= 1'b1;
        end else begin
            sink_hold    <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end
    end

    // compare each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_act want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (act_q.size() == 0) begin
                $error("result beat with nothing expected: value %0d slope %0d",
                       out_if.act_value, out_if.act_slope);
                fails++;
            end else begin
                want = act_q.pop_front();
                if (out_if.act_value !== want.value) begin
                    $error("act_value: expected %0d, got %0d", want.value, out_if.act_value);
                    fails++;
                end
                if (out_if.act_slope !== want.slope) begin
                    $error("act_slope: expected %0d, got %0d", want.slope, out_if.act_slope);
                    fails++;
                end
            end
        end
    end

    // two writes back to back, then the enable drops; only called while idle
    task automatic set_config(input logic [W_MODE-1:0] m, input logic [W_ALPHA-1:0] g);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= W_ALPHA'(m);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ALPHA;
        i_cfg_data <= g;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        mode_q = m;
        gain_q = g;
    endtask

    // let the block drain before touching the registers
    task automatic wait_idle();
        while (act_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // present one beat (after an optional gap) and hold it until taken
    task automatic send_term(input logic signed [W_IN-1:0] w, input logic signed [W_IN-1:0] x,
                             input logic last, input bit fixed, input t_act typed);
        int   gap;
        t_act res;
        gap = 0;
        if (sender_idle_on && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.weight    <= w;
        in_if.sample    <= x;
        in_if.last_term <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (neuron_step(w, x, last, res))
            act_q.push_back(fixed ? typed : res);
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    t_row directed[] = '{
        // elu at reset values: +1.0, zero, top of the q8.24 product
        '{MODE_ELU, 16'd4096, 16'sd4096, 16'sd4096, 1'b1, 1'b1, 32'sd65536, 32'sd65536},
        '{MODE_ELU, 16'd4096, 16'sd0, 16'sd0, 1'b1, 1'b1, 32'sd0, 32'sd65536},
        '{MODE_ELU, 16'd4096, -16'sd32768, -16'sd32768, 1'b1, 1'b1, 32'sd4194304, 32'sd65536},
        // far below -24.0: exp taken as zero, value -alpha, slope 0
        '{MODE_ELU, 16'd4096, -16'sd32768, 16'sd32767, 1'b1, 1'b1, -32'sd65536, 32'sd0},
        '{MODE_ELU, 16'd4096, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{MODE_ELU, 16'd4096, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{MODE_ELU, 16'd4096, -16'sd4096, 16'sd4096, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{MODE_ELU, 16'd4096, 16'sd1, -16'sd1, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{MODE_ELU, 16'd4096, 16'sd123, -16'sd77, 1'b0, 1'b0, 32'sd0, 32'sd0},
        '{MODE_ELU, 16'd4096, -16'sd1, 16'sd1, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{MODE_ELU, 16'd4096, 16'sd16384, -16'sd8192, 1'b1, 1'b0, 32'sd0, 32'sd0},
        // scaled sigmoid; at zero the slope is alpha/2
        '{MODE_SIG, 16'd4096, 16'sd0, 16'sd0, 1'b1, 1'b1, 32'sd0, 32'sd32768},
        '{MODE_SIG, 16'd4096, 16'sd4096, 16'sd4096, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{MODE_SIG, 16'd4096, -16'sd4096, 16'sd4096, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{MODE_SIG, 16'd4096, -16'sd32768, -16'sd32768, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{MODE_SIG, 16'd0, 16'sd12345, 16'sd4096, 1'b1, 1'b1, 32'sd0, 32'sd0},
        '{MODE_SIG, 16'd65535, -16'sd32768, 16'sd32767, 1'b1, 1'b0, 32'sd0, 32'sd0},
        '{MODE_SIG, 16'd65535, 16'sd300, 16'sd700, 1'b1, 1'b0, 32'sd0, 32'sd0},
        // linear, and the spare code behaving as linear
        '{MODE_LIN, 16'd4096, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 32'sd4194048, 32'sd65536},
        '{MODE_SPARE, 16'd65535, 16'sd4096, -16'sd4096, 1'b1, 1'b1, -32'sd65536, 32'sd65536},
        '{MODE_ELU, 16'd65535, -16'sd20000, 16'sd3000, 1'b1, 1'b0, 32'sd0, 32'sd0}
    };

    initial begin
        t_act typed;
        t_act none;
        int   sent;
        int   terms;
        logic [W_MODE-1:0]  m;
        logic [W_ALPHA-1:0] g;
        logic signed [W_IN-1:0] w, x;

        fails = 0;
        cycles = 0;
        sink_hold = 0;
        sender_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        none = '{32'sd0, 32'sd0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MODE;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.weight = '0;
        in_if.sample = '0;
        in_if.last_term = 1'b0;
        out_if.ready = 1'b1;
        mode_q = MODE_ELU;
        gain_q = ALPHA_RST;
        dot_acc = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table, registers changed only between rows when idle
        foreach (directed[i]) begin
            if (directed[i].mode != mode_q || directed[i].gain != gain_q) begin
                drop_valid();
                wait_idle();
                set_config(directed[i].mode, directed[i].gain);
            end
            typed = '{directed[i].value, directed[i].slope};
            send_term(directed[i].w, directed[i].x, directed[i].last, directed[i].fixed, typed);
        end
        drop_valid();

        // random dot products in phases, each with its own register setting
        sent = 0;
        while (sent < RAND_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: g = 16'd0;
                1: g = 16'd65535;
                2: g = ALPHA_RST;
                default: g = 16'($urandom);
            endcase
            m = W_MODE'($urandom_range(0, 3));
            set_config(m, g);
            sender_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on   = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 12)) begin
                terms = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 6);
                for (int t = 0; t < terms; t++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        // small values keep the sum near zero where the curves bend
                        w = W_IN'($signed($urandom_range(0, 4096)) - 2048);
                        x = W_IN'($signed($urandom_range(0, 8192)) - 4096);
                    end else begin
                        w = W_IN'($urandom);
                        x = W_IN'($urandom);
                    end
                    send_term(w, x, t == terms - 1, 1'b0, none);
                    sent++;
                end
            end
            drop_valid();
        end

        // q16.16 saturation: a long run of max products must clamp the value, not wrap
        wait_idle();
        set_config(MODE_LIN, ALPHA_RST);
        sender_idle_on = 1'b0;
        sink_idle_on = 1'b1;
        for (int t = 0; t < SAT_TERMS; t++)
            send_term(-16'sd32768, -16'sd32768, 1'b0, 1'b0, none);
        send_term(-16'sd32768, 16'sd32767, 1'b1, 1'b1, '{32'sd2147483647, 32'sd65536});
        drop_valid();

        while (act_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fails == 0)
            $display("tb_neuron_mac_activation: PASS");
        else
            $display("tb_neuron_mac_activation: FAIL");
        $finish;
    end

endmodule

// ===== neuron_mac_activation.f =====
hw/rtl/nma_pkg.sv
hw/rtl/nma_in_if.sv
hw/rtl/nma_out_if.sv
hw/rtl/nma_div.sv
hw/rtl/neuron_mac_activation.sv
dv/tb_neuron_mac_activation.sv
